// ===== rtl/leu_pkg.sv =====
// shared types and constants for the lorenz euler step block
// coefficient register layout, register indexes, item kinds and datapath widths
// no dependencies
package leu_pkg;

    localparam int COORD_W = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIFF_W  = 50;
    localparam int WIDE_W  = 51;
    localparam int K_W     = 23;
    localparam int FRAC_W  = 16;

    localparam int COEF_A_W = 22;
    localparam int COEF_B_W = 21;
    localparam int COEF_C_W = 21;
    localparam int DT_W     = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic signed [COEF_A_W-1:0] COEF_A_RST = 22'sd774701;
    localparam logic [COEF_B_W-1:0]        COEF_B_RST = 21'd1143603;
    localparam logic [COEF_C_W-1:0]        COEF_C_RST = 21'd163578;
    localparam logic [DT_W-1:0]            DT_RST     = 16'd2359;

    localparam logic [1:0] REG_COEF_A    = 2'd0;
    localparam logic [1:0] REG_COEF_B    = 2'd1;
    localparam logic [1:0] REG_COEF_C    = 2'd2;
    localparam logic [1:0] REG_TIME_STEP = 2'd3;

    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic signed [COEF_A_W-1:0] coef_a;
        logic [COEF_B_W-1:0]        coef_b;
        logic [COEF_C_W-1:0]        coef_c;
        logic [DT_W-1:0]            time_step;
    } t_coefs;

endpackage

// ===== rtl/leu_if.sv =====
// valid/ready stream interfaces for step items and result items
// depends on leu_pkg
interface leu_in_if import leu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [COORD_W-1:0] seed_x;
    logic signed [COORD_W-1:0] seed_y;
    logic signed [COORD_W-1:0] seed_z;

    modport source (output valid, kind, seed_x, seed_y, seed_z, input ready);
    modport sink   (input valid, kind, seed_x, seed_y, seed_z, output ready);
endinterface

interface leu_out_if import leu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== rtl/leu_cfg.sv =====
// apb coefficient register file: sigma, rho, beta and time step
// depends on leu_pkg
module leu_cfg import leu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_coefs            o_coefs
);

    t_coefs     r_coefs;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_coefs = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_a    <= COEF_A_RST;
            r_coefs.coef_b    <= COEF_B_RST;
            r_coefs.coef_c    <= COEF_C_RST;
            r_coefs.time_step <= DT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COEF_A:    r_coefs.coef_a    <= $signed(pwdata[COEF_A_W-1:0]);
                REG_COEF_B:    r_coefs.coef_b    <= pwdata[COEF_B_W-1:0];
                REG_COEF_C:    r_coefs.coef_c    <= pwdata[COEF_C_W-1:0];
                REG_TIME_STEP: r_coefs.time_step <= pwdata[DT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_COEF_A:    prdata = APB_DW'(r_coefs.coef_a);
            REG_COEF_B:    prdata = APB_DW'(r_coefs.coef_b);
            REG_COEF_C:    prdata = APB_DW'(r_coefs.coef_c);
            REG_TIME_STEP: prdata = APB_DW'(r_coefs.time_step);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/leu_mul.sv =====
// shared signed multiplier with registered product
// depends on leu_pkg
module leu_mul import leu_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_op_a,
    input  logic signed [MUL_W-1:0]  i_op_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op_a) * PROD_W'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/leu_core.sv =====
// sequencer and datapath for one euler step over the shared multiplier
// holds the point, intermediates, clamp and the result register
// depends on leu_pkg, leu_mul
module leu_core import leu_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_coefs                    i_coefs,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic signed [COORD_W-1:0] i_seed_x,
    input  logic signed [COORD_W-1:0] i_seed_y,
    input  logic signed [COORD_W-1:0] i_seed_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic                      o_saturated
);

    typedef enum logic [3:0] {
        S_IDLE, S_KA, S_PE, S_NX, S_XY, S_YL, S_YH, S_CZ,
        S_ZLO, S_ZHI, S_ZSUM, S_DONE
    } t_state;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(33'sh1_8000_0000);

    t_state                    r_state;
    logic                      r_ov;
    logic                      r_sat;
    logic                      r_load;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic signed [MUL_W-1:0]   r_d, r_e;
    logic signed [K_W-1:0]     r_k;
    logic signed [DIFF_W-1:0]  r_p, r_m;
    logic signed [WIDE_W-1:0]  r_lo, r_nx, r_ny, r_nz;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DIFF_W-1:0]  prod_hi;
    logic signed [WIDE_W-1:0]  prod_lo;
    logic signed [WIDE_W-1:0]  prod_x2;
    logic signed [MUL_W-1:0]   dt_op;
    logic                      in_fire, done_go;
    logic [2:0]                hi_ovf, lo_ovf;

    leu_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    assign prod_hi = $signed(prod[PROD_W-1:FRAC_W]);
    assign prod_lo = $signed({{(WIDE_W-17){1'b0}}, prod[32:FRAC_W]});
    assign prod_x2 = $signed({prod[WIDE_W-2:0], 1'b0});
    assign dt_op   = $signed({{(MUL_W-DT_W){1'b0}}, i_coefs.time_step});

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign done_go    = (r_state == S_DONE) && (!r_ov || i_out_ready);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IDLE: begin
                mul_a = dt_op;
                mul_b = MUL_W'(i_coefs.coef_a);
            end
            S_KA: begin
                mul_a = MUL_W'(r_x);
                mul_b = r_e;
            end
            S_PE: begin
                mul_a = MUL_W'(r_k);
                mul_b = r_d;
            end
            S_NX: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_y);
            end
            S_XY, S_ZLO: begin
                mul_a = dt_op;
                mul_b = $signed({{(MUL_W-17){1'b0}}, r_p[16:0]});
            end
            S_YL, S_ZHI: begin
                mul_a = dt_op;
                mul_b = $signed(r_p[DIFF_W-1:17]);
            end
            S_YH: begin
                mul_a = $signed({{(MUL_W-COEF_C_W){1'b0}}, i_coefs.coef_c});
                mul_b = MUL_W'(r_z);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // clamp detection on the new coordinates
    always_comb begin
        hi_ovf[0] = r_nx > SAT_MAX;
        hi_ovf[1] = r_ny > SAT_MAX;
        hi_ovf[2] = r_nz > SAT_MAX;
        lo_ovf[0] = r_nx < SAT_MIN;
        lo_ovf[1] = r_ny < SAT_MIN;
        lo_ovf[2] = r_nz < SAT_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_sat   <= 1'b0;
            r_load  <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
        end else begin
            if (i_out_ready && !done_go) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_d    <= MUL_W'(r_y) - MUL_W'(r_x);
                        r_e    <= $signed({{(MUL_W-COEF_B_W){1'b0}}, i_coefs.coef_b})
                                  - MUL_W'(r_z);
                        r_load <= (i_kind == KIND_LOAD);
                        if (i_kind == KIND_LOAD) begin
                            r_nx    <= WIDE_W'(i_seed_x);
                            r_ny    <= WIDE_W'(i_seed_y);
                            r_nz    <= WIDE_W'(i_seed_z);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_KA;
                        end
                    end
                end
                S_KA: begin
                    r_k     <= $signed(prod[K_W+FRAC_W-1:FRAC_W]);
                    r_state <= S_PE;
                end
                S_PE: begin
                    r_p     <= prod_hi;
                    r_state <= S_NX;
                end
                S_NX: begin
                    r_nx    <= WIDE_W'(r_x) + WIDE_W'(prod_hi);
                    r_p     <= r_p - DIFF_W'(r_y);
                    r_state <= S_XY;
                end
                S_XY: begin
                    r_m     <= prod_hi;
                    r_state <= S_YL;
                end
                S_YL: begin
                    r_lo    <= WIDE_W'(r_y) + prod_lo;
                    r_state <= S_YH;
                end
                S_YH: begin
                    r_ny    <= r_lo + prod_x2;
                    r_state <= S_CZ;
                end
                S_CZ: begin
                    r_p     <= r_m - prod_hi;
                    r_state <= S_ZLO;
                end
                S_ZLO: begin
                    r_state <= S_ZHI;
                end
                S_ZHI: begin
                    r_lo    <= WIDE_W'(r_z) + prod_lo;
                    r_state <= S_ZSUM;
                end
                S_ZSUM: begin
                    r_nz    <= r_lo + prod_x2;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (done_go) begin
                        r_x     <= hi_ovf[0] ? SAT_MAX[COORD_W-1:0] :
                                   lo_ovf[0] ? SAT_MIN[COORD_W-1:0] : r_nx[COORD_W-1:0];
                        r_y     <= hi_ovf[1] ? SAT_MAX[COORD_W-1:0] :
                                   lo_ovf[1] ? SAT_MIN[COORD_W-1:0] : r_ny[COORD_W-1:0];
                        r_z     <= hi_ovf[2] ? SAT_MAX[COORD_W-1:0] :
                                   lo_ovf[2] ? SAT_MIN[COORD_W-1:0] : r_nz[COORD_W-1:0];
                        r_sat   <= (|hi_ovf) || (|lo_ovf);
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_x     = r_x;
    assign o_out_y     = r_y;
    assign o_out_z     = r_z;
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("sequencer idle right after an accepted item");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final state");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ov && !i_out_ready)
            |=> (r_state == S_DONE && $stable(r_nx) && $stable(r_x)))
        else $error("pending step lost while result slot busy");

    a_load_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && r_load) |=> !r_sat)
        else $error("saturation flagged on a seed load");
`endif

endmodule

// ===== rtl/lorenz_euler_step.sv =====
// lorenz euler step: step item to result in nine passes through one
// shared 33x33 multiplier plus clamp, load item straight to the final clamp state
// one item at a time; next item accepted the cycle after the result is stored,
// even while that result still waits for transfer
// synchronous active-low reset: point cleared, coefficients to defaults
module lorenz_euler_step import leu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    leu_in_if.sink            i_in,
    leu_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_coefs coefs;

    leu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    leu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (coefs),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_kind      (i_in.kind),
        .i_seed_x    (i_in.seed_x),
        .i_seed_y    (i_in.seed_y),
        .i_seed_z    (i_in.seed_z),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_x     (o_out.out_x),
        .o_out_y     (o_out.out_y),
        .o_out_z     (o_out.out_z),
        .o_saturated (o_out.saturated)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for lorenz_euler_step: directed table then bursty random step/load items,
// results checked against a fixed point euler predictor, coefficients rewritten over apb per phase
// depends on leu_pkg, leu_in_if, leu_out_if and the lorenz_euler_step rtl
module tb_top;
    import leu_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 60;
    localparam int FIRST_RANDOM   = 180;
    localparam int PHASE_ITEMS    = 87;
    localparam int N_PHASES       = 8;
    localparam int N_DIRECTED     = 22;
    localparam int ACC_W          = 80;

    localparam logic signed [ACC_W-1:0] COORD_MAX = 80'sd2147483647;
    localparam logic signed [ACC_W-1:0] COORD_MIN = -80'sd2147483648;

    localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] C_ONE = 32'h0001_0000;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
    } seed_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      sat;
    } point_t;

    typedef struct packed {
        seed_item_t item;
        logic       typed;
        point_t     res;
    } step_row_t;

    typedef struct packed {
        logic [APB_DW-1:0] a;
        logic [APB_DW-1:0] b;
        logic [APB_DW-1:0] c;
        logic [APB_DW-1:0] dt;
    } coef_words_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    leu_in_if  in_if ();
    leu_out_if out_if ();

    lorenz_euler_step u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the coefficients and the point
    t_coefs                    coefs;
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] pt_z;

    point_t expected_points [$];
    int     mismatches    = 0;
    bit     long_hold_req = 1'b0;

    step_row_t directed_rows [N_DIRECTED] = '{
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{'{KIND_LOAD, C_MAX, C_MAX, C_MAX}, 1'b1, '{C_MAX, C_MAX, C_MAX, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, C_MIN, C_MIN, C_MIN}, 1'b1, '{C_MIN, C_MIN, C_MIN, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, C_MAX, C_MIN, C_MAX}, 1'b1, '{C_MAX, C_MIN, C_MAX, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, C_MIN, C_MAX, C_MIN}, 1'b1, '{C_MIN, C_MAX, C_MIN, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, C_ONE, C_ONE, C_ONE}, 1'b1, '{C_ONE, C_ONE, C_ONE, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, 32'hFFFF_FFFF, 32'h0, 32'h1}, 1'b1,
          '{32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}, 1'b1,
          '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0}},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_LOAD, C_ONE, 32'h0002_0000, 32'h0030_0000}, 1'b1,
          '{C_ONE, 32'h0002_0000, 32'h0030_0000, 1'b0}},
        '{'{KIND_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_STEP, 32'h0, 32'h0, 32'h0}, 1'b0, '0}
    };

    coef_words_t coef_plan [N_PHASES] = '{
        '{32'd1310720, 32'd1310720, 32'd1310720, 32'd32768},
        '{32'hFFFD_0000, 32'd0, 32'd0, 32'd0},
        '{32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 32'h0000_FFFF},
        '{32'hFFE0_0000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF},
        '0,
        '0,
        '0,
        '{32'(COEF_A_RST), 32'(COEF_B_RST), 32'(COEF_C_RST), 32'(DT_RST)}
    };

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb_top: mismatch at %0t: %s", $time, what);
    endtask

    function automatic logic signed [COORD_W-1:0] clamp_coord(
        input logic signed [ACC_W-1:0] v, inout logic clipped);
        if (v > COORD_MAX) begin
            clipped = 1'b1;
            return COORD_MAX[COORD_W-1:0];
        end
        if (v < COORD_MIN) begin
            clipped = 1'b1;
            return COORD_MIN[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // advances or seeds the tracked point and returns the result it should produce
    function automatic point_t lorenz_track(input seed_item_t it);
        logic signed [ACC_W-1:0] x, y, z, a, b, c, dt, k, m, nx, ny, nz;
        logic                    clipped;
        point_t                  r;
        if (it.kind == KIND_LOAD) begin
            r = '{it.sx, it.sy, it.sz, 1'b0};
        end else begin
            x  = pt_x;
            y  = pt_y;
            z  = pt_z;
            a  = $signed(coefs.coef_a);
            b  = coefs.coef_b;
            c  = coefs.coef_c;
            dt = coefs.time_step;
            k  = (dt * a) >>> FRAC_W;
            nx = x + ((k * (y - x)) >>> FRAC_W);
            m  = (x * (b - z)) >>> FRAC_W;
            ny = y + ((dt * (m - y)) >>> FRAC_W);
            m  = ((x * y) >>> FRAC_W) - ((c * z) >>> FRAC_W);
            nz = z + ((dt * m) >>> FRAC_W);
            clipped = 1'b0;
            r.x   = clamp_coord(nx, clipped);
            r.y   = clamp_coord(ny, clipped);
            r.z   = clamp_coord(nz, clipped);
            r.sat = clipped;
        end
        pt_x = r.x;
        pt_y = r.y;
        pt_z = r.z;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 5242880) - 32'd2621440;
        endcase
    endfunction

    task automatic write_coef(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COEF_A:    coefs.coef_a    = value[COEF_A_W-1:0];
            REG_COEF_B:    coefs.coef_b    = value[COEF_B_W-1:0];
            REG_COEF_C:    coefs.coef_c    = value[COEF_C_W-1:0];
            REG_TIME_STEP: coefs.time_step = value[DT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(input seed_item_t it, input logic typed, input point_t typed_res);
        point_t res;
        in_if.valid  <= 1'b1;
        in_if.kind   <= it.kind;
        in_if.seed_x <= it.sx;
        in_if.seed_y <= it.sy;
        in_if.seed_z <= it.sz;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        res = lorenz_track(it);
        expected_points = {expected_points, (typed ? typed_res : res)};
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // mostly a seed followed by a run of steps, with the odd early reseed
    task automatic send_random(input int n);
        seed_item_t it;
        int         sent;
        int         burst;
        int         steps_left;
        sent       = 0;
        steps_left = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < n; i++) begin
                if (steps_left == 0 || $urandom_range(0, 49) == 0) begin
                    it.kind    = KIND_LOAD;
                    steps_left = $urandom_range(2, 40);
                end else begin
                    it.kind = KIND_STEP;
                    steps_left--;
                end
                it.sx = rand_coord();
                it.sy = rand_coord();
                it.sz = rand_coord();
                send_item(it, 1'b0, '0);
                sent++;
            end
            idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        coef_words_t w;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.kind   <= KIND_STEP;
        in_if.seed_x <= '0;
        in_if.seed_y <= '0;
        in_if.seed_z <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        coefs = '{COEF_A_RST, COEF_B_RST, COEF_C_RST, DT_RST};
        pt_x  = '0;
        pt_y  = '0;
        pt_z  = '0;
        coef_plan[4] = '{$urandom, $urandom, $urandom, $urandom};
        for (int p = 5; p <= 6; p++)
            coef_plan[p] = '{$urandom_range(0, 1507328) - 32'd196608,
                             $urandom_range(0, 1310720), $urandom_range(0, 1310720),
                             $urandom_range(0, 32768)};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
            idle_input($urandom_range(0, 2));
        end
        long_hold_req = 1'b1;
        send_random(FIRST_RANDOM);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            w = coef_plan[p];
            write_coef(REG_COEF_A, w.a);
            write_coef(REG_COEF_B, w.b);
            write_coef(REG_COEF_C, w.c);
            write_coef(REG_TIME_STEP, w.dt);
            send_random(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && expected_points.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         tick;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // long hold-off so the block fills and backs up the input
            if (long_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (mode)
                SINK_OPEN:   out_if.ready <= 1'b1;
                SINK_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:     out_if.ready <= (tick % 5 != 0);
            endcase
        end
    end

    initial begin : result_check
        point_t want;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("result transfer with no result expected");
                end else begin
                    want = expected_points.pop_front();
                    if (out_if.out_x !== want.x)
                        report_mismatch($sformatf("out_x %h, expected %h", out_if.out_x, want.x));
                    if (out_if.out_y !== want.y)
                        report_mismatch($sformatf("out_y %h, expected %h", out_if.out_y, want.y));
                    if (out_if.out_z !== want.z)
                        report_mismatch($sformatf("out_z %h, expected %h", out_if.out_z, want.z));
                    if (out_if.saturated !== want.sat)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  out_if.saturated, want.sat));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
